[hdl/q2e_pkg.sv]
package q2e_pkg;

    localparam int IN_W   = 16;
    localparam int ROLL_W = 16;
    localparam int PIT_W  = 15;
    localparam int YAW_W  = 16;
    localparam int PROD_W = 40;
    localparam int ACC_W  = 30;
    localparam int ATAN_LEN = 24;

    localparam logic signed [ACC_W-1:0] PI_Q24      = 30'sd52707179;
    localparam logic signed [ACC_W-1:0] HALF_ROUND  = 30'sd1024;
    localparam logic signed [17:0]      PI_Q13      = 18'sd25736;
    localparam logic signed [17:0]      HALF_PI_Q13 = 18'sd12868;

    typedef struct packed {
        logic signed [PROD_W-1:0] sr;
        logic signed [PROD_W-1:0] cr;
        logic signed [PROD_W-1:0] sp;
        logic signed [PROD_W-1:0] sy;
        logic signed [PROD_W-1:0] cy;
    } q2e_terms_t;

    function automatic logic signed [ACC_W-1:0] atan_q24(input logic [4:0] i);
        logic signed [ACC_W-1:0] r;
        case (i)
            5'd0:  r = 30'sd13176795;
            5'd1:  r = 30'sd7778716;
            5'd2:  r = 30'sd4110060;
            5'd3:  r = 30'sd2086331;
            5'd4:  r = 30'sd1047214;
            5'd5:  r = 30'sd524117;
            5'd6:  r = 30'sd262123;
            5'd7:  r = 30'sd131069;
            default: r = (i < 5'd24) ? (30'sd1 <<< (5'd24 - i)) : 30'sd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/q2e_front.sv]
module q2e_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [q2e_pkg::IN_W-1:0] w,
    input  logic signed [q2e_pkg::IN_W-1:0] x,
    input  logic signed [q2e_pkg::IN_W-1:0] y,
    input  logic signed [q2e_pkg::IN_W-1:0] z,
    output logic                            out_valid,
    input  logic                            out_ready,
    output q2e_pkg::q2e_terms_t             terms
);
    localparam int PW = q2e_pkg::PROD_W;
    logic                  st1_vld_reg, st2_vld_reg;
    logic signed [31:0]    p_reg [9];
    q2e_pkg::q2e_terms_t   t_reg;
    logic                  adv;
    logic signed [PW-1:0]  one;

    assign adv       = !st2_vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = st2_vld_reg;
    assign terms     = t_reg;
    assign one       = PW'(1) <<< 30;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
        end else if (adv) begin
            st1_vld_reg <= in_valid;
            st2_vld_reg <= st1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= w * x;  p_reg[1] <= y * z;
            p_reg[2] <= x * x;  p_reg[3] <= y * y;
            p_reg[4] <= w * y;  p_reg[5] <= z * x;
            p_reg[6] <= w * z;  p_reg[7] <= x * y;
            p_reg[8] <= z * z;
            t_reg.sr <= (PW'(p_reg[0]) + PW'(p_reg[1])) <<< 1;
            t_reg.cr <= one - ((PW'(p_reg[2]) + PW'(p_reg[3])) <<< 1);
            t_reg.sp <= (PW'(p_reg[4]) - PW'(p_reg[5])) <<< 1;
            t_reg.sy <= (PW'(p_reg[6]) + PW'(p_reg[7])) <<< 1;
            t_reg.cy <= one - ((PW'(p_reg[3]) + PW'(p_reg[8])) <<< 1);
        end
    end
endmodule

[hdl/q2e_fifo.sv]
module q2e_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= in_data;
    end
endmodule

[hdl/q2e_sqrt.sv]
module q2e_sqrt #(
    parameter int W = 62
) (
    input  logic           aclk,
    input  logic           adv,
    input  logic [W-1:0]   v_in,
    output logic [W/2-1:0] root
);
    localparam int N = W / 2;
    logic [W-1:0]   rem_reg  [N+1];
    logic [N-1:0]   res_reg  [N+1];
    logic [W-1:0]   rem_next [N];
    logic [N-1:0]   res_next [N];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [W+1:0] trial;
            logic [W-1:0] chunk;
            chunk = rem_reg[k] >> (2 * (N - 1 - k));
            trial = {res_reg[k], 2'b01};
            if ({2'b00, chunk} >= trial) begin
                rem_next[k] = rem_reg[k] - W'(trial << (2 * (N - 1 - k)));
                res_next[k] = {res_reg[k][N-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_reg[k];
                res_next[k] = {res_reg[k][N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= v_in;
            res_reg[0] <= '0;
            for (int k = 0; k < N; k++) begin
                rem_reg[k+1] <= rem_next[k];
                res_reg[k+1] <= res_next[k];
            end
        end
    end

    assign root = res_reg[N];
endmodule

[hdl/q2e_cordic.sv]
module q2e_cordic #(
    parameter int STEPS = 16,
    parameter int W     = 44
) (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic signed [W-1:0]           y_in,
    input  logic signed [W-1:0]           x_in,
    output logic signed [17:0]            angle
);
    localparam int AW = q2e_pkg::ACC_W;
    logic signed [W-1:0]  x_reg [STEPS+1];
    logic signed [W-1:0]  y_reg [STEPS+1];
    logic signed [AW-1:0] z_reg [STEPS+1];
    logic signed [W-1:0]  x0, y0;
    logic signed [AW-1:0] z0, zr;

    always_comb begin
        x0 = x_in; y0 = y_in; z0 = '0;
        if (x_in < 0) begin
            z0 = (y_in >= 0) ? q2e_pkg::PI_Q24 : -q2e_pkg::PI_Q24;
            x0 = -x_in; y0 = -y_in;
        end
        if (x_in == 0 && y_in == 0) begin
            x0 = '0; y0 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0] <= x0; y_reg[0] <= y0; z_reg[0] <= z0;
            for (int i = 0; i < STEPS; i++) begin
                if (x_reg[i] == 0 && y_reg[i] == 0) begin
                    x_reg[i+1] <= x_reg[i]; y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end else if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + q2e_pkg::atan_q24(5'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - q2e_pkg::atan_q24(5'(i));
                end
            end
        end
    end

    assign zr    = z_reg[STEPS] + q2e_pkg::HALF_ROUND;
    assign angle = 18'(zr >>> 11);
endmodule

[hdl/q2e_back.sv]
module q2e_back #(
    parameter int STEPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  q2e_pkg::q2e_terms_t                terms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [q2e_pkg::ROLL_W-1:0]  roll,
    output logic signed [q2e_pkg::PIT_W-1:0]   pitch,
    output logic signed [q2e_pkg::YAW_W-1:0]   yaw
);
    localparam int PW  = q2e_pkg::PROD_W;
    localparam int CW  = PW + 4;
    localparam int SQ  = 31;
    localparam int DEP = SQ + 3 + STEPS;

    logic                 adv;
    logic [DEP:0]         vld_reg;
    logic [61:0]          sq_reg;
    logic [61:0]          arg_reg;
    q2e_pkg::q2e_terms_t  t_d_reg [SQ+3];
    logic [30:0]          cp;
    logic signed [17:0]   ar, ap, ay;
    logic [1:0]           clamp_d_reg [STEPS+1];
    logic signed [PW-1:0] one;
    logic [q2e_pkg::ROLL_W+q2e_pkg::PIT_W+q2e_pkg::YAW_W-1:0] skid_reg [2];
    logic                 wsel_reg, rsel_reg;
    logic [1:0]           cnt_reg;
    logic signed [17:0]   rs, ps, ys;
    logic                 push, pop;

    assign one = PW'(1) <<< 30;

    // pipeline holds only when a result waits, the output queue is full and out_ready is low
    assign adv      = !vld_reg[DEP] || cnt_reg != 2'd2 || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn)  vld_reg <= '0;
        else if (adv)  vld_reg <= {vld_reg[DEP-1:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg    <= 62'($signed(terms.sp[31:0]) * $signed(terms.sp[31:0]));
            arg_reg   <= (62'(1) << 60) - sq_reg;
            t_d_reg[0]  <= terms;
            for (int k = 1; k < SQ + 3; k++) begin
                t_d_reg[k]  <= t_d_reg[k-1];
            end
            clamp_d_reg[0] <= {t_d_reg[SQ+2].sp >= one, t_d_reg[SQ+2].sp <= -one};
            for (int k = 1; k <= STEPS; k++) clamp_d_reg[k] <= clamp_d_reg[k-1];
        end
    end

    q2e_sqrt #(.W(62)) u_sqrt (
        .aclk(aclk), .adv(adv), .v_in(arg_reg), .root(cp)
    );

    q2e_cordic #(.STEPS(STEPS), .W(CW)) u_roll (
        .aclk(aclk), .adv(adv), .y_in(CW'(t_d_reg[SQ+2].sr)),
        .x_in(CW'(t_d_reg[SQ+2].cr)), .angle(ar)
    );
    q2e_cordic #(.STEPS(STEPS), .W(CW)) u_pitch (
        .aclk(aclk), .adv(adv), .y_in(CW'(t_d_reg[SQ+2].sp)),
        .x_in(CW'($signed({1'b0, cp}))), .angle(ap)
    );
    q2e_cordic #(.STEPS(STEPS), .W(CW)) u_yaw (
        .aclk(aclk), .adv(adv), .y_in(CW'(t_d_reg[SQ+2].sy)),
        .x_in(CW'(t_d_reg[SQ+2].cy)), .angle(ay)
    );

    always_comb begin
        rs = (ar > q2e_pkg::PI_Q13) ? q2e_pkg::PI_Q13 :
             (ar < -q2e_pkg::PI_Q13) ? -q2e_pkg::PI_Q13 : ar;
        ys = (ay > q2e_pkg::PI_Q13) ? q2e_pkg::PI_Q13 :
             (ay < -q2e_pkg::PI_Q13) ? -q2e_pkg::PI_Q13 : ay;
        ps = (ap > q2e_pkg::HALF_PI_Q13) ? q2e_pkg::HALF_PI_Q13 :
             (ap < -q2e_pkg::HALF_PI_Q13) ? -q2e_pkg::HALF_PI_Q13 : ap;
        if (clamp_d_reg[STEPS][1])      ps = q2e_pkg::HALF_PI_Q13;
        else if (clamp_d_reg[STEPS][0]) ps = -q2e_pkg::HALF_PI_Q13;
    end

    assign push = vld_reg[DEP] && adv;
    assign pop  = out_valid && out_ready;
    assign out_valid = cnt_reg != 2'd0;
    assign {yaw, pitch, roll} = skid_reg[rsel_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; wsel_reg <= 1'b0; rsel_reg <= 1'b0;
        end else begin
            if (push) wsel_reg <= !wsel_reg;
            if (pop)  rsel_reg <= !rsel_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) skid_reg[wsel_reg] <= {16'(-ys), 15'(ps), 16'(-rs)};
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && cnt_reg == 2'd2)) else $error("result queue overflow");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (ps <= q2e_pkg::HALF_PI_Q13 && ps >= -q2e_pkg::HALF_PI_Q13))
        else $error("pitch out of range");
`endif
endmodule

[hdl/quaternion_to_euler.sv]
// quaternion to euler angles: each s_axis transaction carries one q1.15 quaternion and
// gives one m_axis transaction with roll and yaw (negated) in q3.13 and pitch in q2.13
// radians. one quaternion is accepted per cycle while s_axis_tready is high; the result
// passes through 2 front stages, the queue, 2 stages for the pitch argument, the
// 32-register square root, CORDIC_STEPS + 1 cordic registers and the output queue before
// it reaches m_axis. a stalled output holds the back pipeline while the queue lets the
// front keep accepting until it fills.
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // roll_angle, pitch_angle, yaw_angle, zero pad
);
    q2e_pkg::q2e_terms_t f_terms, q_terms;
    logic f_vld, f_rdy, q_vld, q_rdy;
    logic signed [15:0] roll, yaw;
    logic signed [14:0] pitch;

    q2e_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .w(s_axis_tdata[15:0]), .x(s_axis_tdata[31:16]),
        .y(s_axis_tdata[47:32]), .z(s_axis_tdata[63:48]),
        .out_valid(f_vld), .out_ready(f_rdy), .terms(f_terms)
    );

    q2e_fifo #(.WIDTH($bits(q2e_pkg::q2e_terms_t))) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_vld), .in_ready(f_rdy), .in_data(f_terms),
        .out_valid(q_vld), .out_ready(q_rdy), .out_data(q_terms)
    );

    q2e_back #(.STEPS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_vld), .in_ready(q_rdy), .terms(q_terms),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .roll(roll), .pitch(pitch), .yaw(yaw)
    );

    assign m_axis_tdata = {1'b0, yaw, pitch, roll};
endmodule
